>>> src/tes_pkg.sv
package tes_pkg;

	localparam int SlotsDef = 16;
	localparam int MaxFire = 16;
	localparam int FireCntW = $clog2(MaxFire);

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_SCHED  = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_SET    = 2'd3
	} kind_t;

	typedef enum logic {
		ST_OK   = 1'b0,
		ST_FULL = 1'b1
	} status_t;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  delay_us;
		logic [15:0]  event_id;
		logic [15:0]  event_value;
		logic         repeating;
		logic [63:0]  new_time;
	} req_t;

	typedef struct packed {
		logic         is_fired;
		logic [15:0]  fired_id;
		logic [15:0]  fired_value;
		logic         status;
		logic         last;
	} rsp_t;

	typedef struct packed {
		logic [63:0]  deadline;
		logic [31:0]  period;
		logic [15:0]  id;
		logic [15:0]  value;
		logic         repeats;
	} slot_t;

	typedef struct packed {
		logic    load;
		logic    scan_clr;
		logic    scan_rd;
		logic    scan_step;
		logic    sched_write;
		logic    take_best;
		logic    emit_fire;
		logic    emit_last;
		logic    emit_ack;
		status_t ack_status;
	} ctl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  scan_end;
		logic  free_hit;
		logic  found;
		logic  have_pend;
		logic  cnt_last;
		logic  out_free;
	} dp_stat_t;

endpackage

>>> src/tes_ram.sv
module tes_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> src/tes_ctrl.sv
module tes_ctrl import tes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  kind_t    req_kind,
	output logic     req_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_DECIDE,
		S_FREE,
		S_FLUSH,
		S_ACK
	} state_t;

	state_t  state_q;
	state_t  state_d;
	status_t ack_status_q;
	status_t ack_status_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.ack_status = ack_status_q;
		state_d = state_q;
		ack_status_d = ack_status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					case (req_kind)
						KIND_TICK:   state_d = S_SCAN;
						KIND_CANCEL: state_d = S_SCAN;
						KIND_SCHED:  state_d = S_FREE;
						default: begin
							ack_status_d = ST_OK;
							state_d = S_ACK;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_end) begin
					state_d = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				// last read is evaluated in this cycle
				if (stat.kind == KIND_CANCEL) begin
					ack_status_d = ST_OK;
					state_d = S_ACK;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.found) begin
					if (!stat.have_pend || stat.out_free) begin
						// previous fire goes out now that we know another follows
						cmd.emit_fire = stat.have_pend;
						cmd.take_best = 1'b1;
						cmd.scan_clr = 1'b1;
						state_d = stat.cnt_last ? S_FLUSH : S_SCAN;
					end
				end else if (stat.have_pend) begin
					state_d = S_FLUSH;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				if (stat.free_hit) begin
					cmd.sched_write = 1'b1;
					ack_status_d = ST_OK;
					state_d = S_ACK;
				end else if (stat.scan_end) begin
					ack_status_d = ST_FULL;
					state_d = S_ACK;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.emit_fire = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ACK: begin
				if (stat.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ack_status_q <= ST_OK;
		end else begin
			state_q <= state_d;
			ack_status_q <= ack_status_d;
		end
	end

endmodule

>>> src/tes_dp.sv
module tes_dp import tes_pkg::*; #(
	parameter int SLOTS = SlotsDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SlotW = $bits(slot_t);

	// latched beat
	kind_t        kind_q;
	logic [31:0]  delay_q;
	logic [15:0]  id_q;
	logic [15:0]  value_q;
	logic         rep_q;

	logic [63:0]      clock_q;
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] done_q;
	logic [AW-1:0]    scan_q;
	logic             chk_s1;
	logic [AW-1:0]    idx_s1;
	logic             found_q;
	slot_t            best_q;
	logic [AW-1:0]    best_idx_q;
	logic             have_pend_q;
	logic [15:0]      pend_id_q;
	logic [15:0]      pend_value_q;
	logic [FireCntW-1:0] fire_cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	slot_t            ram_wdata;
	logic [SlotW-1:0] ram_rdata;
	slot_t            rd;
	slot_t            new_slot;
	slot_t            rearm_slot;
	logic             tick_hit;
	logic             cancel_hit;
	logic             out_free;

	assign rd = slot_t'(ram_rdata);

	always_comb begin
		new_slot.deadline = clock_q + 64'(delay_q);
		new_slot.period   = delay_q;
		new_slot.id       = id_q;
		new_slot.value    = value_q;
		new_slot.repeats  = rep_q;
		rearm_slot = best_q;
		rearm_slot.deadline = best_q.deadline + 64'(best_q.period);
	end

	assign ram_we    = cmd.sched_write | (cmd.take_best & best_q.repeats);
	assign ram_waddr = cmd.sched_write ? scan_q : best_idx_q;
	assign ram_wdata = cmd.sched_write ? new_slot : rearm_slot;

	tes_ram #(
		.Width(SlotW),
		.Depth(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	// due, not yet fired this tick, and strictly earlier than the best so far
	assign tick_hit = chk_s1 && (kind_q == KIND_TICK) && valid_q[idx_s1] && !done_q[idx_s1]
		&& (rd.deadline <= clock_q) && (!found_q || (rd.deadline < best_q.deadline));
	assign cancel_hit = chk_s1 && (kind_q == KIND_CANCEL) && valid_q[idx_s1]
		&& (rd.id == id_q) && (rd.value == value_q);

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		stat.kind      = kind_q;
		stat.scan_end  = (scan_q == AW'(SLOTS - 1));
		stat.free_hit  = !valid_q[scan_q];
		stat.found     = found_q;
		stat.have_pend = have_pend_q;
		stat.cnt_last  = (fire_cnt_q == FireCntW'(MaxFire - 1));
		stat.out_free  = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			delay_q <= req.delay_us;
			id_q    <= req.event_id;
			value_q <= req.event_value;
			rep_q   <= req.repeating;
		end
		if (tick_hit) begin
			best_q     <= rd;
			best_idx_q <= idx_s1;
		end
		idx_s1 <= scan_q;
		if (cmd.take_best) begin
			pend_id_q    <= best_q.id;
			pend_value_q <= best_q.value;
		end
		if (cmd.emit_fire) begin
			rsp_q <= '{is_fired: 1'b1, fired_id: pend_id_q, fired_value: pend_value_q,
				status: ST_OK, last: cmd.emit_last};
		end else if (cmd.emit_ack) begin
			rsp_q <= '{is_fired: 1'b0, fired_id: '0, fired_value: '0,
				status: cmd.ack_status, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_TICK;
			clock_q     <= '0;
			valid_q     <= '0;
			done_q      <= '0;
			scan_q      <= '0;
			chk_s1      <= 1'b0;
			found_q     <= 1'b0;
			have_pend_q <= 1'b0;
			fire_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			chk_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				kind_q      <= req.kind;
				done_q      <= '0;
				have_pend_q <= 1'b0;
				fire_cnt_q  <= '0;
				case (req.kind)
					KIND_TICK: clock_q <= clock_q + 64'd1;
					KIND_SET:  clock_q <= req.new_time;
					default: begin
					end
				endcase
			end
			if (cmd.scan_clr) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_rd || cmd.scan_step) begin
				scan_q <= scan_q + AW'(1);
			end
			if (tick_hit) begin
				found_q <= 1'b1;
			end
			if (cancel_hit) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.sched_write) begin
				valid_q[scan_q] <= 1'b1;
			end
			if (cmd.take_best) begin
				done_q[best_idx_q] <= 1'b1;
				have_pend_q <= 1'b1;
				fire_cnt_q <= fire_cnt_q + FireCntW'(1);
				if (!best_q.repeats) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.emit_fire || cmd.emit_ack) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

>>> src/timer_event_scheduler.sv
// Timer event scheduler: a 64-bit microsecond clock plus a table of SLOTS timer events held
// in a slot RAM with separate read and write ports and one valid flag per slot. Request beats
// (tick, schedule, cancel, set time) are taken one at a time; req_stall stays high until the
// beat's work is done, while the response register may still hold an earlier beat. Schedule
// searches the valid flags for the lowest free slot one slot per cycle. Cancel reads every
// slot once. A tick runs one full pass over the slot RAM for each event it fires plus a final
// pass that finds nothing due (no final pass when 16 fire). A tick fires at most 16 events;
// any still due stay pending for the next tick. Each fired event gives one response beat,
// acknowledge beats carry is_fired low, and last marks the final beat of each request (a tick
// that fires nothing gives no beat). Extra cycles are added whenever rsp_stall holds a beat.
module timer_event_scheduler import tes_pkg::*; #(
	parameter int SLOTS = SlotsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	tes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_kind (req.kind),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tes_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
